// File: design/rau_pkg.sv
// Shared types, constants and opcodes for the rational arithmetic unit.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package rau_pkg;

    localparam int OPW = 32;
    localparam int DENW = OPW - 1;
    localparam int RESW = 64;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_SIMP = 3'd4;

    typedef struct packed {
        logic [2:0]             kind;
        logic signed [OPW-1:0]  a_numerator;
        logic [DENW-1:0]        a_denominator;
        logic signed [OPW-1:0]  b_numerator;
        logic [DENW-1:0]        b_denominator;
    } in_item_t;

    typedef struct packed {
        logic signed [RESW-1:0] result_numerator;
        logic signed [RESW-1:0] result_denominator;
        logic                   zero_denominator;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD_LOAD,
        ST_GCD_DIV,
        ST_DIV1,
        ST_MUL1,
        ST_DIV2,
        ST_DIV3,
        ST_MUL2,
        ST_SIMP_DIV,
        ST_FINISH,
        ST_OUT
    } exec_state_t;

endpackage
`default_nettype wire

// File: design/rau_divider.sv
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg for the result width; divide by zero gives quotient 0.
`default_nettype none
module rau_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [rau_pkg::RESW-1:0]  dividend,
    input  wire logic [rau_pkg::RESW-1:0]  divisor,
    output logic                           done,
    output logic [rau_pkg::RESW-1:0]       quotient,
    output logic [rau_pkg::RESW-1:0]       remainder
);
    localparam int W = rau_pkg::RESW;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] quo_reg, quo_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic zero_reg, zero_next;
    logic done_reg, done_next;
    logic [W:0] trial;
    logic [W:0] shifted;

    // Shift in one dividend bit and try to subtract
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        shifted = {rem_reg, quo_reg[W-1]};
        trial = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(W);
            busy_next = 1'b1;
            zero_next = (divisor == '0);
        end
        else if (busy_reg)
        begin
            if (trial[W])
            begin
                rem_next = shifted[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quotient = zero_reg ? '0 : quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// File: design/rau_front.sv
// Front end: accepts requests into a two-entry queue for the back end.
// Depends on rau_pkg for the request type.
`default_nettype none
module rau_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire rau_pkg::in_item_t in_item,
    output logic                   q_valid,
    input  wire logic              q_take,
    output rau_pkg::in_item_t      q_item
);
    rau_pkg::in_item_t mem_reg [2];
    logic wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign pop = q_take && q_valid;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rd_reg];

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= in_item;
    end
endmodule
`default_nettype wire

// File: design/rau_back.sv
// Back end: sequencer that runs each request through GCD, divides and multiplies as its kind needs.
// Depends on rau_pkg and rau_divider.
`default_nettype none
module rau_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_take,
    input  wire rau_pkg::in_item_t q_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rau_pkg::out_item_t     out_item
);
    localparam int W = rau_pkg::RESW;
    localparam int OW = rau_pkg::OPW;

    rau_pkg::exec_state_t st_reg, st_next;
    logic [2:0] kind_reg, kind_next;
    logic [W-1:0] na_reg, na_next, nb_reg, nb_next;
    logic [W-1:0] da_reg, da_next, db_reg, db_next;
    logic [W-1:0] x_reg, x_next, y_reg, y_next;
    logic [W-1:0] g_reg, g_next, lcm_reg, lcm_next, t1_reg, t1_next;
    logic [W-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [W-1:0] mul_a, mul_b, mul_p, mul_c, mul_d, mul_q;
    logic [W-1:0] mul_ax, mul_bx, mul_cx, mul_dx;
    logic div_start, div_done;
    logic [W-1:0] div_n, div_d, div_q, div_r;
    logic [W-1:0] mag_na;

    rau_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(div_n), .divisor(div_d),
        .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    assign mag_na = na_reg[W-1] ? (W'(0) - na_reg) : na_reg;

    // Two 32x32 products: every multiplicand fits in 32 bits signed, so sign-extend
    // the low word and keep the low 64 bits of the product
    assign mul_ax = {{(W-OW){mul_a[OW-1]}}, mul_a[OW-1:0]};
    assign mul_bx = {{(W-OW){mul_b[OW-1]}}, mul_b[OW-1:0]};
    assign mul_cx = {{(W-OW){mul_c[OW-1]}}, mul_c[OW-1:0]};
    assign mul_dx = {{(W-OW){mul_d[OW-1]}}, mul_d[OW-1:0]};
    assign mul_p = mul_ax * mul_bx;
    assign mul_q = mul_cx * mul_dx;

    // Sequence the operation
    always_comb
    begin
        st_next = st_reg;
        kind_next = kind_reg;
        na_next = na_reg; nb_next = nb_reg; da_next = da_reg; db_next = db_reg;
        x_next = x_reg; y_next = y_reg; g_next = g_reg;
        lcm_next = lcm_reg; t1_next = t1_reg; rn_next = rn_reg; rd_next = rd_reg;
        q_take = 1'b0;
        div_start = 1'b0;
        div_n = x_reg;
        div_d = y_reg;
        mul_a = '0;
        mul_b = '0;
        mul_c = '0;
        mul_d = '0;
        case (st_reg)
            rau_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    kind_next = q_item.kind;
                    na_next = W'(q_item.a_numerator);
                    nb_next = W'(q_item.b_numerator);
                    da_next = W'(q_item.a_denominator);
                    db_next = W'(q_item.b_denominator);
                    st_next = rau_pkg::ST_GCD_LOAD;
                end
            end
            rau_pkg::ST_GCD_LOAD:
            begin
                case (kind_reg)
                    rau_pkg::KIND_ADD, rau_pkg::KIND_SUB:
                    begin
                        x_next = da_reg; y_next = db_reg;
                        st_next = rau_pkg::ST_GCD_DIV;
                    end
                    rau_pkg::KIND_SIMP:
                    begin
                        x_next = mag_na; y_next = da_reg;
                        st_next = rau_pkg::ST_GCD_DIV;
                    end
                    rau_pkg::KIND_MUL:
                    begin
                        mul_a = na_reg; mul_b = nb_reg; rn_next = mul_p;
                        mul_c = da_reg; mul_d = db_reg; rd_next = mul_q;
                        st_next = rau_pkg::ST_OUT;
                    end
                    rau_pkg::KIND_DIV:
                    begin
                        mul_a = na_reg; mul_b = db_reg; rn_next = mul_p;
                        mul_c = da_reg; mul_d = nb_reg; rd_next = mul_q;
                        st_next = rau_pkg::ST_OUT;
                    end
                    default:
                    begin
                        rn_next = '0; rd_next = '0;
                        st_next = rau_pkg::ST_OUT;
                    end
                endcase
            end
            rau_pkg::ST_GCD_DIV:
            begin
                if (y_reg == '0)
                begin
                    g_next = x_reg;
                    if (kind_reg == rau_pkg::KIND_SIMP)
                    begin
                        rn_next = na_reg; rd_next = da_reg;
                        if (x_reg > W'(1))
                        begin
                            div_n = mag_na; div_d = x_reg; div_start = 1'b1;
                            st_next = rau_pkg::ST_SIMP_DIV;
                        end
                        else
                            st_next = rau_pkg::ST_OUT;
                    end
                    else
                    begin
                        div_n = da_reg; div_d = x_reg; div_start = 1'b1;
                        st_next = rau_pkg::ST_DIV1;
                    end
                end
                else
                begin
                    div_start = 1'b1;
                    st_next = rau_pkg::ST_FINISH;
                end
            end
            rau_pkg::ST_FINISH:
            begin
                // one Euclid step: (x, y) <- (y, x mod y)
                if (div_done)
                begin
                    x_next = y_reg; y_next = div_r;
                    st_next = rau_pkg::ST_GCD_DIV;
                end
            end
            rau_pkg::ST_DIV1:
            begin
                if (div_done)
                begin
                    mul_a = div_q; mul_b = db_reg;
                    lcm_next = mul_p;
                    st_next = rau_pkg::ST_MUL1;
                end
            end
            rau_pkg::ST_MUL1:
            begin
                div_n = lcm_reg; div_d = da_reg; div_start = 1'b1;
                st_next = rau_pkg::ST_DIV2;
            end
            rau_pkg::ST_DIV2:
            begin
                if (div_done)
                begin
                    mul_a = na_reg; mul_b = div_q;
                    t1_next = mul_p;
                    div_n = lcm_reg; div_d = db_reg; div_start = 1'b1;
                    st_next = rau_pkg::ST_DIV3;
                end
            end
            rau_pkg::ST_DIV3:
            begin
                if (div_done)
                begin
                    mul_a = nb_reg; mul_b = div_q;
                    rn_next = (kind_reg == rau_pkg::KIND_ADD) ? t1_reg + mul_p
                                                             : t1_reg - mul_p;
                    rd_next = lcm_reg;
                    st_next = rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_SIMP_DIV:
            begin
                if (div_done)
                begin
                    rn_next = na_reg[W-1] ? W'(0) - div_q : div_q;
                    div_n = da_reg; div_d = g_reg; div_start = 1'b1;
                    st_next = rau_pkg::ST_MUL2;
                end
            end
            rau_pkg::ST_MUL2:
            begin
                if (div_done)
                begin
                    rd_next = div_q;
                    st_next = rau_pkg::ST_OUT;
                end
            end
            rau_pkg::ST_OUT:
            begin
                if (!out_stall)
                    st_next = rau_pkg::ST_IDLE;
            end
            default:
                st_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= rau_pkg::ST_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        na_reg <= na_next; nb_reg <= nb_next; da_reg <= da_next; db_reg <= db_next;
        x_reg <= x_next; y_reg <= y_next; g_reg <= g_next;
        lcm_reg <= lcm_next; t1_reg <= t1_next; rn_reg <= rn_next; rd_reg <= rd_next;
    end

    assign out_valid = (st_reg == rau_pkg::ST_OUT);
    assign out_item.result_numerator = rn_reg;
    assign out_item.result_denominator = rd_reg;
    assign out_item.zero_denominator = (rd_reg == '0);
endmodule
`default_nettype wire

// File: design/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide of two fractions and
// simplify of the first. Multiply and divide go from the request queue through
// ST_GCD_LOAD to the result; add, subtract and simplify run a Euclidean GCD on a
// shared bit-serial divider, then three more divides for add and subtract, or two
// for simplify when the GCD exceeds one. A two-entry request queue in front accepts
// new requests meanwhile, until it is full.
// Depends on rau_pkg, rau_front, rau_back, rau_divider.
`default_nettype none
module rational_arithmetic_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire rau_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rau_pkg::out_item_t      out_item
);
    logic q_valid, q_take;
    rau_pkg::in_item_t q_item;

    rau_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_item(q_item), .out_valid(out_valid), .out_stall(out_stall),
        .out_item(out_item)
    );

`ifndef SYNTHESIS
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.zero_denominator == (out_item.result_denominator == '0)))
        else $error("zero flag disagrees with denominator");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid)
        else $error("back end took from empty queue");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed");
`endif
endmodule
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for rational_arithmetic_unit: predicts each request's
// fraction result and compares it field by field. Depends on rau_pkg.
`default_nettype none
module testbench;

    typedef logic [rau_pkg::DENW-1:0] den_t;
    typedef logic [rau_pkg::OPW-1:0] num_t;

    // Expected-fraction store and checker
    class fraction_scoreboard;
        rau_pkg::out_item_t pending[$];
        int mismatches;
        int requests;
        int results;

        function logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
            logic [63:0] t;
            while (y != 0)
            begin
                t = y;
                y = x % y;
                x = t;
            end
            return x;
        endfunction

        function logic [63:0] quot(logic [63:0] x, logic [63:0] y);
            return (y != 0) ? x / y : 64'd0;
        endfunction

        function logic [63:0] mag(logic [63:0] v);
            return v[63] ? -v : v;
        endfunction

        function void note_request(rau_pkg::in_item_t it);
            logic [63:0] na, nb, da, db, g, lcm, rn, rd, m;
            rau_pkg::out_item_t e;
            na = {{(64-rau_pkg::OPW){it.a_numerator[rau_pkg::OPW-1]}}, it.a_numerator};
            nb = {{(64-rau_pkg::OPW){it.b_numerator[rau_pkg::OPW-1]}}, it.b_numerator};
            da = {{(64-rau_pkg::DENW){1'b0}}, it.a_denominator};
            db = {{(64-rau_pkg::DENW){1'b0}}, it.b_denominator};
            rn = 0;
            rd = 0;
            case (it.kind)
                rau_pkg::KIND_ADD, rau_pkg::KIND_SUB:
                begin
                    g = euclid_gcd(da, db);
                    lcm = quot(da, g) * db;
                    rn = (it.kind == rau_pkg::KIND_ADD)
                         ? na * quot(lcm, da) + nb * quot(lcm, db)
                         : na * quot(lcm, da) - nb * quot(lcm, db);
                    rd = lcm;
                end
                rau_pkg::KIND_MUL:
                begin
                    rn = na * nb;
                    rd = da * db;
                end
                rau_pkg::KIND_DIV:
                begin
                    rn = na * db;
                    rd = da * nb;
                end
                rau_pkg::KIND_SIMP:
                begin
                    g = euclid_gcd(mag(na), da);
                    rn = na;
                    rd = da;
                    if (g > 1)
                    begin
                        m = mag(na) / g;
                        rn = na[63] ? -m : m;
                        rd = da / g;
                    end
                end
                default: ;
            endcase
            e.result_numerator = rn;
            e.result_denominator = rd;
            e.zero_denominator = (rd == 0);
            pending.push_back(e);
            requests++;
        endfunction

        function void check_result(rau_pkg::out_item_t got);
            rau_pkg::out_item_t e;
            results++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.result_numerator !== e.result_numerator ||
                got.result_denominator !== e.result_denominator ||
                got.zero_denominator !== e.zero_denominator)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d/%0d z%b got %0d/%0d z%b",
                             e.result_numerator, e.result_denominator,
                             e.zero_denominator, got.result_numerator,
                             got.result_denominator, got.zero_denominator);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    rau_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    rau_pkg::out_item_t out_item;

    fraction_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int hold_cycles;

    rational_arithmetic_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    initial
    begin
        #400000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stall, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cycles <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_item);
            if (hold_off && hold_cycles < 3000)
            begin
                hold_cycles <= hold_cycles + 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Send one request, idling first at random
    task automatic send_request(rau_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(it);
    endtask

    function automatic den_t pick_den();
        case ($urandom_range(5))
            0: return den_t'(1);
            1: return {rau_pkg::DENW{1'b1}};
            2: return den_t'($urandom_range(1, 12));
            3: return den_t'($urandom_range(1, 1000));
            default: return den_t'($urandom() | $urandom_range(1));
        endcase
    endfunction

    function automatic num_t pick_num();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return num_t'($urandom_range(0, 40) - 20);
            3: return num_t'($urandom_range(0, 2000) * ($urandom_range(1) ? 1 : -1));
            default: return num_t'($urandom());
        endcase
    endfunction

    function automatic rau_pkg::in_item_t random_request();
        rau_pkg::in_item_t it;
        it.kind = ($urandom_range(19) == 0)
                  ? 3'($urandom_range(5, 7))
                  : 3'($urandom_range(rau_pkg::KIND_ADD, rau_pkg::KIND_SIMP));
        it.a_numerator = pick_num();
        it.b_numerator = pick_num();
        it.a_denominator = pick_den();
        it.b_denominator = pick_den();
        // shared factors make simplify and lcm interesting
        if ($urandom_range(3) == 0)
        begin
            it.a_numerator = num_t'(it.a_numerator * 6);
            it.a_denominator = den_t'($urandom_range(1, 300) * 6);
        end
        if ($urandom_range(40) == 0)
            it.a_denominator = '0;
        if ($urandom_range(40) == 0)
            it.b_denominator = '0;
        return it;
    endfunction

    task automatic run_phase(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
            send_request(random_request());
    endtask

    initial
    begin
        rau_pkg::in_item_t it;
        int k;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every operation at field extremes, zero fraction, zero denominators
        for (k = rau_pkg::KIND_ADD; k <= 7; k++)
        begin
            it.kind = 3'(k);
            it.a_numerator = 32'h8000_0000;
            it.a_denominator = {rau_pkg::DENW{1'b1}};
            it.b_numerator = 32'h7fff_ffff;
            it.b_denominator = den_t'(1);
            send_request(it);
            it.a_numerator = '0;
            it.a_denominator = '0;
            it.b_numerator = '0;
            it.b_denominator = '0;
            send_request(it);
        end
        it = '{rau_pkg::KIND_DIV, 32'sd3, 31'd4, 32'sd0, 31'd5};
        send_request(it);
        it = '{rau_pkg::KIND_DIV, 32'sd3, 31'd4, -32'sd7, 31'd5};
        send_request(it);
        it = '{rau_pkg::KIND_SIMP, -32'sd12, 31'd18, 32'sd0, 31'd1};
        send_request(it);
        it = '{rau_pkg::KIND_SIMP, 32'sd7, 31'd9, 32'sd0, 31'd1};
        send_request(it);
        it = '{rau_pkg::KIND_ADD, 32'sd1, 31'd6, 32'sd1, 31'd4};
        send_request(it);
        it = '{rau_pkg::KIND_SUB, 32'sd1, 31'd6, 32'sd1, 31'd0};
        send_request(it);

        // Long receiver hold-off while requests keep coming
        hold_off = 1'b1;
        run_phase(30, 0, 0);
        hold_off = 1'b0;

        run_phase(540, 34, 81);
        run_phase(540, 81, 34);
        run_phase(540, 0, 0);
        in_valid <= 1'b0;

        // Drain
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (500) @(posedge clk);

        $display("Checked %0d requests and %0d results across all five operations,",
                 sb.requests, sb.results);
        $display("with stalls on both sides and one long output hold-off.");
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
